FILE: hw/rtl/scd_pkg.sv
// Shared types, widths, constants and constant tables of the stain
// deconvolution pixel pipeline. No dependencies.
package scd_pkg;

  // Formats and widths
  localparam int COEF_FRAC_BITS = 12;
  localparam int COEF_W         = 18;
  localparam int PIX_W          = 8;
  localparam int PIX_N          = 1 << PIX_W;
  localparam int OUT_W          = 8;
  localparam int CFG_IDX_W      = 2;

  localparam int OD_W           = 17;               // Q9.8 signed density
  localparam int PROD_W         = OD_W + COEF_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int ONE_POS        = 8 + COEF_FRAC_BITS;

  localparam int D16_W          = 26;               // 255 - s in Q16
  localparam int LOG_W          = 33;               // log2(255) in Q30
  localparam int NUM_W          = LOG_W + 1 + D16_W;
  localparam int DIV_SHIFT      = 26;
  localparam int DIV_SH         = 8;                // 255 = 2^8 - 1
  localparam int X_W            = 32;
  localparam int RECIP_SHIFT    = 40;
  localparam int RECIP_W        = 33;

  localparam int FRAC_W         = 20;
  localparam int IDX_W          = 6;
  localparam int REM_W          = FRAC_W - IDX_W;
  localparam int Y_W            = 24;
  localparam int SH_W           = Y_W - FRAC_W;
  localparam int SH_MAX         = 9;
  localparam int EXP_N          = (1 << IDX_W) + 1;
  localparam int EXP_IDX_W      = IDX_W + 1;
  localparam int EXP_W          = 32;
  localparam int DIFF_W         = 26;
  localparam int OUT_SHIFT      = 32;
  localparam int V_W            = EXP_W + SH_MAX + 1;

  // Special outcomes of the density sum
  typedef enum logic [1:0] {
    SPC_NONE = 2'd0,
    SPC_SAT  = 2'd1,
    SPC_ZERO = 2'd2
  } spc_e;

  // Register map of the coefficient port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_RED   = 2'd0,
    REG_COEF_GREEN = 2'd1,
    REG_COEF_BLUE  = 2'd2
  } cfg_reg_e;

  localparam logic signed [COEF_W-1:0] COEF_RED_RST   = 18'sd4096;
  localparam logic signed [COEF_W-1:0] COEF_GREEN_RST = 18'sd0;
  localparam logic signed [COEF_W-1:0] COEF_BLUE_RST  = 18'sd0;

  typedef struct packed {
    logic signed [COEF_W-1:0] red;
    logic signed [COEF_W-1:0] green;
    logic signed [COEF_W-1:0] blue;
  } coef_t;

  typedef struct packed {
    spc_e           spc;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] q_est;
  } arg_t;

  // Datapath constants
  localparam logic signed [SUM_W-1:0] S_BASE     = SUM_W'(longint'(255) <<< ONE_POS);
  localparam logic signed [SUM_W-1:0] S_ZERO_LIM = SUM_W'(longint'(288) <<< ONE_POS);
  localparam logic signed [NUM_W-1:0] NUM_HALF   = NUM_W'(longint'(255) <<< (DIV_SHIFT - 1));
  localparam logic [X_W-1:0]          X_OFS      = X_W'(longint'(255) <<< (FRAC_W + 1));
  localparam logic [RECIP_W-1:0]      RECIP      =
    RECIP_W'((longint'(1) <<< RECIP_SHIFT) / 255);
  localparam logic [X_W-1:0]          DIV_255    = X_W'((1 << DIV_SH) - 1);
  localparam logic [SH_W-1:0]         SH_LIMIT   = SH_W'(SH_MAX);
  localparam logic [V_W-1:0]          ROUND_OUT  = V_W'(longint'(1) <<< (OUT_SHIFT - 1));
  localparam logic [V_W-OUT_SHIFT-1:0] RES_MAX   = (V_W-OUT_SHIFT)'(255);
  localparam logic [OUT_W-1:0]        OUT_MAX    = OUT_W'(255);

  // log2(n) in Q30 for n in 1..256, by repeated squaring
  function automatic logic [63:0] log2_q30(input logic [63:0] n);
    logic [63:0] x;
    logic [63:0] frac;
    int unsigned k;
    k    = 0;
    frac = '0;
    while (k < 8 && (n >> (k + 1)) != 64'd0) k++;
    x = n << (30 - k);
    for (int i = 0; i < 30; i++) begin
      x    = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        x       = x >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(k) << 30) | frac;
  endfunction

  localparam logic [LOG_W-1:0]      LOG255_Q30 = LOG_W'(log2_q30(64'd255));
  localparam logic signed [LOG_W:0] LOG255_S   = {1'b0, LOG255_Q30};

  // Floor quotient of two unsigned values, one bit per step (table build only)
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  typedef logic signed [OD_W-1:0] od_table_t [PIX_N];

  function automatic od_table_t build_od_table();
    od_table_t tab;
    longint    num;
    longint    t;
    for (int v = 0; v < PIX_N; v++) begin
      num = longint'(65280) * (longint'(LOG255_Q30) - longint'(log2_q30(64'(v + 1))));
      t   = num + (longint'(LOG255_Q30) >>> 1) + 64 * longint'(LOG255_Q30);
      tab[v] = OD_W'(longint'(udiv64(64'(t), 64'(LOG255_Q30))) - 64);
    end
    return tab;
  endfunction

  localparam od_table_t OD_TABLE = build_od_table();

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 64'd0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  typedef logic [EXP_W-1:0] exp_table_t [EXP_N];

  // 2^(k/64) in Q30
  function automatic exp_table_t build_exp_table();
    exp_table_t  tab;
    logic [63:0] c;
    logic [63:0] e;
    c = 64'd2 << 30;
    for (int k = 0; k < 6; k++) c = isqrt64(c << 30);
    e      = 64'd1 << 30;
    tab[0] = EXP_W'(e);
    for (int k = 1; k < EXP_N; k++) begin
      e      = (e * c + (64'd1 << 29)) >> 30;
      tab[k] = EXP_W'(e);
    end
    return tab;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

FILE: hw/rtl/scd_if.sv
// Channel interfaces of the stain deconvolution pixel block: pixel in,
// intensity out, coefficient writes. Depends on scd_pkg.
interface scd_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [scd_pkg::PIX_W-1:0]   red;
  logic [scd_pkg::PIX_W-1:0]   green;
  logic [scd_pkg::PIX_W-1:0]   blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface scd_result_if;
  logic                        valid;
  logic                        ready;
  logic [scd_pkg::OUT_W-1:0]   stain_intensity;

  modport source (output valid, stain_intensity, input ready);
  modport sink   (input valid, stain_intensity, output ready);
endinterface

interface scd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [scd_pkg::CFG_IDX_W-1:0]     index;
  logic signed [scd_pkg::COEF_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/stain_color_deconvolution_pixel.sv
// Top level of the stain deconvolution pixel block: coefficient registers and
// the three pipeline sections. Depends on scd_pkg, scd_if, scd_od_mac,
// scd_exp_arg and scd_exp2.
//
// Usage:
//   pixel_i  takes one RGB word (red, green, blue) per accepted handshake.
//   result_o gives one stain_intensity word per pixel, in pixel order.
//   cfg_i    writes the three signed coefficients (index 0 red, 1 green,
//            2 blue; other indexes are dropped). It is always ready. Write it
//            only while no pixel is in flight.
// Throughput: one pixel per clock while result_o is ready. Eleven register stages in a row, each
//   with its own valid bit; the last one is the output register.
// Path: a pixel's result word is valid at result_o once it has passed through
//   every stage in order: scd_od_mac, scd_exp_arg, then scd_exp2.
// Stall: a stage loads when it is empty or its word moves on, so bubbles
//   close up and pixel_i stays ready while the pipeline has a free slot,
//   even with a finished word waiting at result_o. Once every stage is full
//   and result_o is not ready, pixel_i.ready drops; nothing is lost.
// Reset: clears all valid bits and loads the coefficients 1.0 / 0 / 0 (the
//   red density alone); no clearing pass, the tables are constants.
module stain_color_deconvolution_pixel (
  input  logic         clk_i,
  input  logic         rst_ni,
  scd_pixel_if.sink    pixel_i,
  scd_cfg_if.sink      cfg_i,
  scd_result_if.source result_o
);

  scd_pkg::coef_t coef_q;
  logic           cfg_acc;

  logic                             sum_valid, sum_ready;
  logic signed [scd_pkg::SUM_W-1:0] sum;
  logic                             arg_valid, arg_ready;
  scd_pkg::arg_t                    arg;

  // Coefficient registers: a write lands in the next cycle, unknown indexes drop
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.red   <= scd_pkg::COEF_RED_RST;
      coef_q.green <= scd_pkg::COEF_GREEN_RST;
      coef_q.blue  <= scd_pkg::COEF_BLUE_RST;
    end else if (cfg_acc) begin
      case (scd_pkg::cfg_reg_e'(cfg_i.index))
        scd_pkg::REG_COEF_RED:   coef_q.red   <= cfg_i.data;
        scd_pkg::REG_COEF_GREEN: coef_q.green <= cfg_i.data;
        scd_pkg::REG_COEF_BLUE:  coef_q.blue  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Densities from the lookup table, weighted and summed
  scd_od_mac u_od_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pixel_i.valid),
    .in_ready_o  (pixel_i.ready),
    .red_i       (pixel_i.red),
    .green_i     (pixel_i.green),
    .blue_i      (pixel_i.blue),
    .coef_i      (coef_q),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .sum_o       (sum)
  );

  // Flag the saturating cases, build the power-of-two argument in Q20
  scd_exp_arg u_exp_arg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .sum_i       (sum),
    .out_valid_o (arg_valid),
    .out_ready_i (arg_ready),
    .arg_o       (arg)
  );

  // Interpolate 2^frac, shift by the integer part, round and saturate
  scd_exp2 u_exp2 (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (arg_valid),
    .in_ready_o        (arg_ready),
    .arg_i             (arg),
    .out_valid_o       (result_o.valid),
    .out_ready_i       (result_o.ready),
    .stain_intensity_o (result_o.stain_intensity)
  );

`ifndef SYNTHESIS
  // Input back-pressure only comes from a full pipe behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pixel_i.ready |-> (result_o.valid && !result_o.ready))
    else $error("pixel input stalled while the output was free");

  // A write to an unmapped index leaves every coefficient alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_acc && !(cfg_i.index == scd_pkg::REG_COEF_RED ||
                  cfg_i.index == scd_pkg::REG_COEF_GREEN ||
                  cfg_i.index == scd_pkg::REG_COEF_BLUE)) |=> $stable(coef_q))
    else $error("unmapped coefficient write changed a register");

  // A red write lands on the red coefficient in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_acc && cfg_i.index == scd_pkg::REG_COEF_RED) |=>
      (coef_q.red == $past(cfg_i.data)))
    else $error("red coefficient write lost");
`endif

endmodule

FILE: hw/rtl/scd_od_mac.sv
// Density lookup and weighted sum: three register stages (table, multiply, add).
// Depends on scd_pkg.
module scd_od_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [scd_pkg::PIX_W-1:0]         red_i,
  input  logic [scd_pkg::PIX_W-1:0]         green_i,
  input  logic [scd_pkg::PIX_W-1:0]         blue_i,
  input  scd_pkg::coef_t                    coef_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [scd_pkg::SUM_W-1:0]  sum_o
);

  logic v1_q, v2_q, v3_q;
  logic ld1, ld2, ld3;

  logic signed [scd_pkg::OD_W-1:0]   od_r_q, od_g_q, od_b_q;
  logic signed [scd_pkg::PROD_W-1:0] p_r_q, p_g_q, p_b_q;
  logic signed [scd_pkg::SUM_W-1:0]  sum_q;

  // A stage loads when empty or when its word moves on
  assign ld3        = !v3_q || out_ready_i;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_ready_o = ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      od_r_q <= scd_pkg::OD_TABLE[red_i];
      od_g_q <= scd_pkg::OD_TABLE[green_i];
      od_b_q <= scd_pkg::OD_TABLE[blue_i];
    end
    if (ld2) begin
      p_r_q <= od_r_q * $signed(coef_i.red);
      p_g_q <= od_g_q * $signed(coef_i.green);
      p_b_q <= od_b_q * $signed(coef_i.blue);
    end
    if (ld3) begin
      sum_q <= scd_pkg::SUM_W'(p_r_q) + scd_pkg::SUM_W'(p_g_q) + scd_pkg::SUM_W'(p_b_q);
    end
  end

  assign out_valid_o = v3_q;
  assign sum_o       = sum_q;

endmodule

FILE: hw/rtl/scd_exp_arg.sv
// Exponent argument: classify the sum, scale by log2(255), divide by 255 with
// a reciprocal multiply. Four register stages. Depends on scd_pkg.
module scd_exp_arg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [scd_pkg::SUM_W-1:0]  sum_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output scd_pkg::arg_t                     arg_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic ld1, ld2, ld3, ld4;

  scd_pkg::spc_e spc_d, spc1_q, spc2_q, spc3_q, spc4_q;

  logic signed [scd_pkg::SUM_W:0]            diff_s;
  logic signed [scd_pkg::D16_W-1:0]          d16_q;
  logic signed [scd_pkg::NUM_W-1:0]          num_q;
  logic signed [scd_pkg::NUM_W-1:0]          num_rnd;
  logic [scd_pkg::X_W-1:0]                   x_d, x3_q, x4_q;
  logic [scd_pkg::X_W+scd_pkg::RECIP_W-1:0]  recip_prod;
  logic [scd_pkg::Y_W-1:0]                   q_est_q;

  assign ld4        = !v4_q || out_ready_i;
  assign ld3        = !v3_q || ld4;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_ready_o = ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
    end
  end

  // Non-positive sum saturates high, a sum of 288 or more rounds to zero
  always_comb begin
    if (sum_i[scd_pkg::SUM_W-1] || sum_i == '0) begin
      spc_d = scd_pkg::SPC_SAT;
    end else if (sum_i >= scd_pkg::S_ZERO_LIM) begin
      spc_d = scd_pkg::SPC_ZERO;
    end else begin
      spc_d = scd_pkg::SPC_NONE;
    end
  end

  assign diff_s     = (scd_pkg::SUM_W+1)'(scd_pkg::S_BASE) - (scd_pkg::SUM_W+1)'(sum_i);
  assign num_rnd    = num_q + scd_pkg::NUM_HALF;
  // floor(n / (255 * 2^26)) = floor(floor(n / 2^26) / 255); offset keeps it positive
  assign x_d        = scd_pkg::X_W'(num_rnd >>> scd_pkg::DIV_SHIFT) + scd_pkg::X_OFS;
  assign recip_prod = x3_q * scd_pkg::RECIP;

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      spc1_q <= spc_d;
      d16_q  <= scd_pkg::D16_W'(diff_s >>> (scd_pkg::COEF_FRAC_BITS - 8));
    end
    if (ld2) begin
      spc2_q <= spc1_q;
      num_q  <= scd_pkg::LOG255_S * d16_q;
    end
    if (ld3) begin
      spc3_q <= spc2_q;
      x3_q   <= x_d;
    end
    if (ld4) begin
      spc4_q  <= spc3_q;
      x4_q    <= x3_q;
      q_est_q <= recip_prod[scd_pkg::RECIP_SHIFT +: scd_pkg::Y_W];
    end
  end

  assign out_valid_o = v4_q;
  assign arg_o.spc   = spc4_q;
  assign arg_o.x     = x4_q;
  assign arg_o.q_est = q_est_q;

endmodule

FILE: hw/rtl/scd_exp2.sv
// Power of two: quotient correction, table interpolation, shift and round to
// the output register. Four register stages. Depends on scd_pkg.
module scd_exp2 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  scd_pkg::arg_t               arg_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [scd_pkg::OUT_W-1:0]   stain_intensity_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic ld1, ld2, ld3, ld4;

  scd_pkg::spc_e spc1_q, spc2_q, spc3_q;

  logic [scd_pkg::X_W-1:0]                    rem_x;
  logic [scd_pkg::Y_W-1:0]                    y;
  logic [scd_pkg::SH_W-1:0]                   sh_d, sh1_q, sh2_q, sh3_q;
  logic [scd_pkg::IDX_W-1:0]                  idx1_q;
  logic [scd_pkg::REM_W-1:0]                  rem1_q, rem2_q;
  logic [scd_pkg::EXP_W-1:0]                  e0_q, m_q;
  logic [scd_pkg::DIFF_W-1:0]                 de_q;
  logic [scd_pkg::DIFF_W+scd_pkg::REM_W-1:0]  interp;
  logic [scd_pkg::EXP_IDX_W-1:0]              idx_lo, idx_hi;
  logic [scd_pkg::V_W-1:0]                    shifted, rounded;
  logic [scd_pkg::V_W-scd_pkg::OUT_SHIFT-1:0] res;
  logic [scd_pkg::OUT_W-1:0]                  res_sat, out_d, out_q;

  assign ld4        = !v4_q || out_ready_i;
  assign ld3        = !v3_q || ld4;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_ready_o = ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
    end
  end

  // Estimate is exact or one low: bump it when the remainder reaches 255
  assign rem_x = arg_i.x - ((scd_pkg::X_W'(arg_i.q_est) << scd_pkg::DIV_SH)
                 - scd_pkg::X_W'(arg_i.q_est));
  assign y     = (rem_x >= scd_pkg::DIV_255) ? arg_i.q_est + scd_pkg::Y_W'(1) : arg_i.q_est;
  assign sh_d  = (y[scd_pkg::Y_W-1:scd_pkg::FRAC_W] > scd_pkg::SH_LIMIT)
                 ? scd_pkg::SH_LIMIT : y[scd_pkg::Y_W-1:scd_pkg::FRAC_W];

  assign idx_lo = scd_pkg::EXP_IDX_W'(idx1_q);
  assign idx_hi = idx_lo + scd_pkg::EXP_IDX_W'(1);
  assign interp = de_q * rem2_q;

  assign shifted = scd_pkg::V_W'(m_q) << sh3_q;
  assign rounded = shifted + scd_pkg::ROUND_OUT;
  assign res     = rounded[scd_pkg::V_W-1:scd_pkg::OUT_SHIFT];
  assign res_sat = (res > scd_pkg::RES_MAX) ? scd_pkg::OUT_MAX : scd_pkg::OUT_W'(res);

  always_comb begin
    case (spc3_q)
      scd_pkg::SPC_NONE: out_d = res_sat;
      scd_pkg::SPC_SAT:  out_d = scd_pkg::OUT_MAX;
      scd_pkg::SPC_ZERO: out_d = '0;
      default:           out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      spc1_q <= arg_i.spc;
      sh1_q  <= sh_d;
      idx1_q <= y[scd_pkg::FRAC_W-1:scd_pkg::REM_W];
      rem1_q <= y[scd_pkg::REM_W-1:0];
    end
    if (ld2) begin
      spc2_q <= spc1_q;
      sh2_q  <= sh1_q;
      rem2_q <= rem1_q;
      e0_q   <= scd_pkg::EXP_TABLE[idx_lo];
      de_q   <= scd_pkg::DIFF_W'(scd_pkg::EXP_TABLE[idx_hi] - scd_pkg::EXP_TABLE[idx_lo]);
    end
    if (ld3) begin
      spc3_q <= spc2_q;
      sh3_q  <= sh2_q;
      m_q    <= e0_q + scd_pkg::EXP_W'(interp >> scd_pkg::REM_W);
    end
    if (ld4) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o       = v4_q;
  assign stain_intensity_o = out_q;

endmodule
